// ===== design/odsvf_pkg.sv =====
// shared types and constants for the overdrive / dc blocker / svf lowpass block
// no dependencies
`default_nettype none

package odsvf_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 27;
	localparam int unsigned MUL_A_W    = 41;
	localparam int unsigned MUL_B_W    = 26;
	localparam int unsigned MUL_P_W    = MUL_A_W + MUL_B_W;

	localparam logic [16:0] DC_POLE_Q16 = 17'd64881;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DRIVE_GAIN      = 3'd0,
		REG_ASYM_OFFSET     = 3'd1,
		REG_ASYM_CORRECTION = 3'd2,
		REG_VOLUME_GAIN     = 3'd3,
		REG_CUTOFF_COEF     = 3'd4,
		REG_DAMPING_COEF    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [26:0]        drive_gain;
		logic [22:0]        asym_offset;
		logic signed [21:0] asym_correction;
		logic [22:0]        volume_gain;
		logic [16:0]        cutoff_coef;
		logic [16:0]        damping_coef;
	} cfg_regs_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_DRV,
		OP_POLE,
		OP_VOL,
		OP_BF,
		OP_BQ,
		OP_H,
		OP_HF,
		OP_BUPD
	} op_t;

endpackage

`default_nettype wire

// ===== design/odsvf_cfg.sv =====
// configuration register file: drive, asymmetry, volume and filter coefficients
// depends on odsvf_pkg
`default_nettype none

module odsvf_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [odsvf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [odsvf_pkg::CFG_DATA_W-1:0] cfg_data,
	output odsvf_pkg::cfg_regs_t                  regs
);
	import odsvf_pkg::*;

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.drive_gain      <= 27'd458752;
			regs_q.asym_offset     <= 23'd1782579;
			regs_q.asym_correction <= -22'sd1403781;
			regs_q.volume_gain     <= 23'd3732930;
			regs_q.cutoff_coef     <= 17'd55731;
			regs_q.damping_coef    <= 17'd19005;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DRIVE_GAIN:      regs_q.drive_gain      <= cfg_data[26:0];
				REG_ASYM_OFFSET:     regs_q.asym_offset     <= cfg_data[22:0];
				REG_ASYM_CORRECTION: regs_q.asym_correction <= cfg_data[21:0];
				REG_VOLUME_GAIN:     regs_q.volume_gain     <= cfg_data[22:0];
				REG_CUTOFF_COEF:     regs_q.cutoff_coef     <= cfg_data[16:0];
				REG_DAMPING_COEF:    regs_q.damping_coef    <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/odsvf_ctrl.sv =====
// sequencer: steps one sample through the shared multiplier schedule
// depends on odsvf_pkg
`default_nettype none

module odsvf_ctrl (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  wire logic      m_tready,
	output odsvf_pkg::op_t op
);
	import odsvf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POLE,
		ST_VOL,
		ST_BF,
		ST_BQ,
		ST_H,
		ST_HF,
		ST_BUPD
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		case (state_q)
			ST_IDLE: op = s_tvalid ? OP_DRV : OP_NOP;
			ST_POLE: op = OP_POLE;
			ST_VOL:  op = OP_VOL;
			ST_BF:   op = OP_BF;
			ST_BQ:   op = OP_BQ;
			ST_H:    op = OP_H;
			ST_HF:   op = OP_HF;
			ST_BUPD: op = out_free ? OP_BUPD : OP_NOP;
			default: op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_POLE;
					end
				end
				ST_POLE: state_q <= ST_VOL;
				ST_VOL:  state_q <= ST_BF;
				ST_BF:   state_q <= ST_BQ;
				ST_BQ:   state_q <= ST_H;
				ST_H:    state_q <= ST_HF;
				ST_HF:   state_q <= ST_BUPD;
				ST_BUPD: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/odsvf_dp.sv =====
// datapath: shared multiplier, waveshaper, dc blocker and svf integrators
// depends on odsvf_pkg
`default_nettype none

module odsvf_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire odsvf_pkg::op_t      op,
	input  wire odsvf_pkg::cfg_regs_t regs,
	input  wire logic signed [15:0]  sample_in,
	output logic signed [23:0]       sample_out
);
	import odsvf_pkg::*;

	localparam logic signed [51:0] S40_MAX = 52'sd549755813887;
	localparam logic signed [51:0] S40_MIN = -52'sd549755813888;
	localparam logic signed [32:0] T_FOUR  = 33'sd4194304;
	localparam logic signed [32:0] T_TWO   = 33'sd2097152;

	function automatic logic signed [39:0] sat40(input logic signed [51:0] v);
		logic signed [39:0] r;
		if (v > S40_MAX) begin
			r = S40_MAX[39:0];
		end else if (v < S40_MIN) begin
			r = S40_MIN[39:0];
		end else begin
			r = v[39:0];
		end
		return r;
	endfunction

	function automatic logic signed [50:0] rnd16(input logic signed [MUL_P_W-1:0] p);
		logic signed [MUL_P_W-1:0] r;
		r = p + MUL_P_W'(32768);
		return r[MUL_P_W-1:16];
	endfunction

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod_q;
	logic signed [24:0]        t_q;
	logic signed [50:0]        pole_q;
	logic signed [39:0]        h_q;
	logic signed [23:0]        out_q;
	logic signed [39:0]        prev_in_q;
	logic signed [39:0]        prev_out_q;
	logic signed [39:0]        lp_q;
	logic signed [39:0]        bp_q;

	logic signed [32:0] t_raw;
	logic signed [24:0] t_clamp;
	logic signed [28:0] s_val;
	logic signed [50:0] prod_rnd;
	logic signed [40:0] lp_bias;
	logic signed [32:0] lp_shift;
	logic signed [23:0] out_sat;

	always_comb begin
		case (op)
			OP_DRV: begin
				mul_a = MUL_A_W'(regs.drive_gain);
				mul_b = MUL_B_W'(sample_in);
			end
			OP_POLE: begin
				mul_a = MUL_A_W'(prev_out_q);
				mul_b = MUL_B_W'(DC_POLE_Q16);
			end
			OP_VOL: begin
				mul_a = MUL_A_W'(regs.volume_gain);
				mul_b = MUL_B_W'(t_q);
			end
			OP_BF: begin
				mul_a = MUL_A_W'(bp_q);
				mul_b = MUL_B_W'(regs.cutoff_coef);
			end
			OP_BQ: begin
				mul_a = MUL_A_W'(bp_q);
				mul_b = MUL_B_W'(regs.damping_coef);
			end
			OP_HF: begin
				mul_a = MUL_A_W'(h_q);
				mul_b = MUL_B_W'(regs.cutoff_coef);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// waveshaper: scale, offset, clamp to +-2 beyond +-4
	always_comb begin
		t_raw = $signed(prod_q[44:12]) + $signed({10'd0, regs.asym_offset});
		if (t_raw > T_FOUR) begin
			t_clamp = T_TWO[24:0];
		end else if (t_raw < -T_FOUR) begin
			t_clamp = -(T_TWO[24:0]);
		end else begin
			t_clamp = t_raw[24:0];
		end
	end

	assign s_val    = prod_q[48:20];
	assign prod_rnd = rnd16(prod_q);
	assign lp_bias  = 41'(lp_q) + 41'sd128;
	assign lp_shift = lp_bias[40:8];

	always_comb begin
		if (lp_shift > 33'sd8388607) begin
			out_sat = 24'sh7FFFFF;
		end else if (lp_shift < -33'sd8388608) begin
			out_sat = 24'sh800000;
		end else begin
			out_sat = lp_shift[23:0];
		end
	end

	assign sample_out = out_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_DRV, OP_POLE, OP_VOL, OP_BF, OP_BQ, OP_HF: prod_q <= mul_a * mul_b;
			default: ;
		endcase
		case (op)
			OP_POLE: t_q <= t_clamp + 25'(regs.asym_correction);
			OP_VOL:  pole_q <= prod_rnd;
			OP_H:    h_q <= sat40(52'(prev_out_q) - 52'(lp_q) - 52'(prod_rnd));
			OP_BUPD: out_q <= out_sat;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_in_q  <= '0;
			prev_out_q <= '0;
			lp_q       <= '0;
			bp_q       <= '0;
		end else begin
			case (op)
				OP_BF: begin
					prev_in_q  <= 40'(s_val);
					prev_out_q <= sat40(52'(s_val) - 52'(prev_in_q) + 52'(pole_q));
				end
				OP_BQ:   lp_q <= sat40(52'(lp_q) + 52'(prod_rnd));
				OP_BUPD: bp_q <= sat40(52'(bp_q) + 52'(prod_rnd));
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/overdrive_dcblock_svf_lowpass.sv =====
// Overdrive waveshaper, DC blocker and state-variable lowpass filter, one sample
// per transaction. The result is loaded into the output register in the final step,
// and a new sample is accepted only after the previous one has finished all steps:
// one signed multiplier is shared by all six products of the chain and each product
// is registered before use. A new sample is taken while the previous result still
// waits on the output; the last step then holds until the output register is free.
// Registers must be written through the cfg channel only while the block is idle;
// the block itself does not enforce this. Unknown indexes are ignored.
// depends on odsvf_pkg, odsvf_cfg, odsvf_ctrl, odsvf_dp
`default_nettype none

module overdrive_dcblock_svf_lowpass (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [15:0]                      s_tdata,  // [15:0] sample_in
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [23:0]                           m_tdata,  // [23:0] sample_out
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [odsvf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [odsvf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import odsvf_pkg::*;

	cfg_regs_t          regs;
	op_t                op;
	logic signed [23:0] sample_out;

	odsvf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	odsvf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.op       (op)
	);

	odsvf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.regs       (regs),
		.sample_in  ($signed(s_tdata)),
		.sample_out (sample_out)
	);

	assign m_tdata = sample_out;

endmodule

`default_nettype wire
